[rtl/mwa_pkg.sv]
package mwa_pkg;

  // Datapath width and default depth of the queue between front and back.
  localparam int unsigned MWA_XLEN        = 64;
  localparam int unsigned MWA_QUEUE_DEPTH = 4;

  // Operation codes.
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_NEG = 3'd5,
    OP_SHL = 3'd6,
    OP_SAR = 3'd7
  } mwa_op_t;

  // Operand width codes.
  typedef enum logic [1:0] {
    W8  = 2'd0,
    W16 = 2'd1,
    W32 = 2'd2,
    W64 = 2'd3
  } mwa_width_t;

  // Classified item as it travels from the front to the back.
  // For div and mod, a and b already hold the magnitudes.
  typedef struct packed {
    mwa_op_t    op;
    mwa_width_t width_sel;
    logic       ext_sign;
    logic       dz;
    logic       neg_q;
    logic       neg_r;
    logic [63:0] a;
    logic [63:0] b;
  } mwa_item_t;

  // Contents of one stage of the execute pipeline.
  typedef struct packed {
    mwa_op_t    op;
    mwa_width_t width_sel;
    logic       ext_sign;
    logic       dz;
    logic       neg_q;
    logic       neg_r;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] dvs;
  } mwa_stage_t;

  // One finished result.
  typedef struct packed {
    logic [63:0] value;
    logic        valid;
    logic        status;
  } mwa_res_t;

  // Mask that keeps the low width bits.
  function automatic logic [63:0] mwa_mask(mwa_width_t ws);
    logic [63:0] m;
    case (ws)
      W8:      m = 64'h0000_0000_0000_00FF;
      W16:     m = 64'h0000_0000_0000_FFFF;
      W32:     m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  // Number of bits in the operand width.
  function automatic logic [6:0] mwa_bits(mwa_width_t ws);
    logic [6:0] n;
    case (ws)
      W8:      n = 7'd8;
      W16:     n = 7'd16;
      W32:     n = 7'd32;
      default: n = 7'd64;
    endcase
    return n;
  endfunction

  // Sign extension from the operand width to 64 bits.
  function automatic logic [63:0] mwa_sext(logic [63:0] v, mwa_width_t ws);
    logic [63:0] r;
    case (ws)
      W8:      r = {{56{v[7]}}, v[7:0]};
      W16:     r = {{48{v[15]}}, v[15:0]};
      W32:     r = {{32{v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

[rtl/multi_width_integer_alu.sv]
// Throughput: one item per cycle while the output buffer has room; a full
// buffer with a finished item waiting stalls the pipeline. The 64-stage
// pipelined divider, one quotient bit per stage, sets the latency, and every
// operation takes the same path.
// Reset (synchronous, active low) empties the input queue, the pipeline and
// the output buffer; no arithmetic state survives between items.
module multi_width_integer_alu import mwa_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = MWA_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_mode,
  input  logic [1:0]  in_width_sel,
  input  logic        in_is_signed,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_result_value,
  output logic        out_result_valid,
  output logic        out_status
);

  mwa_item_t front_item;
  mwa_item_t head_item;
  logic      q_empty;
  logic      q_pop;

  // Front: mask and classify the incoming item.
  mwa_front u_front (
    .in_mode      (in_mode),
    .in_width_sel (in_width_sel),
    .in_is_signed (in_is_signed),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .item         (front_item)
  );

  // Queue between the front and the execute pipeline.
  mwa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .wdata (front_item),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (head_item)
  );

  // Back: execute pipeline and output buffer.
  mwa_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .item             (head_item),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_result_value (out_result_value),
    .out_result_valid (out_result_valid),
    .out_status       (out_status)
  );

endmodule

[rtl/mwa_front.sv]
module mwa_front import mwa_pkg::*; (
  input  logic [2:0]  in_mode,
  input  logic [1:0]  in_width_sel,
  input  logic        in_is_signed,
  input  logic [63:0] in_operand_a,
  input  logic [63:0] in_operand_b,
  output mwa_item_t   item
);

  // Mask the operands, flag a zero divisor and turn signed division
  // operands into magnitudes with the signs of quotient and remainder.
  always_comb begin
    mwa_op_t     op;
    mwa_width_t  ws;
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] sa;
    logic [63:0] sb;
    logic        is_div;
    op     = mwa_op_t'(in_mode);
    ws     = mwa_width_t'(in_width_sel);
    m      = mwa_mask(ws);
    a      = in_operand_a & m;
    b      = in_operand_b & m;
    sa     = mwa_sext(a, ws);
    sb     = mwa_sext(b, ws);
    is_div = (op == OP_DIV) || (op == OP_MOD);

    item           = '0;
    item.op        = op;
    item.width_sel = ws;
    item.ext_sign  = ((op == OP_MUL) || is_div) ? in_is_signed : 1'b1;
    item.dz        = is_div && (b == 64'd0);
    item.a         = a;
    item.b         = b;
    if (is_div && in_is_signed) begin
      item.a     = sa[63] ? (64'd0 - sa) : sa;
      item.b     = sb[63] ? (64'd0 - sb) : sb;
      item.neg_q = sa[63] ^ sb[63];
      item.neg_r = sa[63];
    end
  end

endmodule

[rtl/mwa_queue.sv]
module mwa_queue import mwa_pkg::*; #(
  parameter int unsigned DEPTH = MWA_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  mwa_item_t wdata,
  input  logic      pop,
  output logic      empty,
  output mwa_item_t rdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mwa_item_t       mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/mwa_back.sv]
module mwa_back import mwa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  mwa_item_t   item,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_result_value,
  output logic        out_result_valid,
  output logic        out_status
);

  localparam int unsigned NSTEP = MWA_XLEN;

  mwa_stage_t       st_r   [NSTEP+1];
  mwa_stage_t       st_nxt [NSTEP+1];
  logic [NSTEP:0]   vld_r;
  logic             adv;
  mwa_res_t         fin;
  mwa_res_t         ofifo_r [2];
  logic             owp_r, orp_r;
  logic [1:0]       ocnt_r, ocnt_nxt;
  logic             ofull;
  logic             owr;
  logic             ord;

  // The pipeline moves unless a finished item cannot enter the output buffer.
  assign adv   = !(vld_r[NSTEP] && ofull);
  assign q_pop = adv && !q_empty;

  // Entry stage: simple operations finish here, the multiply forms its
  // partial products and the division sets up its remainder and dividend.
  always_comb begin
    logic [6:0]  wb;
    logic        big;
    logic [5:0]  n;
    logic [31:0] pp_ab;
    logic [31:0] pp_ba;
    wb    = mwa_bits(item.width_sel);
    big   = (item.b >= {57'd0, wb});
    n     = big ? 6'(wb - 7'd1) : item.b[5:0];
    pp_ab = item.a[31:0] * item.b[63:32];
    pp_ba = item.a[63:32] * item.b[31:0];

    st_nxt[0]           = '0;
    st_nxt[0].op        = item.op;
    st_nxt[0].width_sel = item.width_sel;
    st_nxt[0].ext_sign  = item.ext_sign;
    st_nxt[0].dz        = item.dz;
    st_nxt[0].neg_q     = item.neg_q;
    st_nxt[0].neg_r     = item.neg_r;
    case (item.op)
      OP_ADD: st_nxt[0].quo = item.a + item.b;
      OP_SUB: st_nxt[0].quo = item.a - item.b;
      OP_NEG: st_nxt[0].quo = 64'd0 - item.a;
      OP_SHL: st_nxt[0].quo = big ? 64'd0 : (item.a << item.b[5:0]);
      OP_SAR: st_nxt[0].quo = 64'($signed(mwa_sext(item.a, item.width_sel)) >>> n);
      OP_MUL: begin
        st_nxt[0].quo = {32'd0, item.a[31:0]} * {32'd0, item.b[31:0]};
        st_nxt[0].rem = {pp_ab, pp_ba};
      end
      OP_DIV, OP_MOD: begin
        st_nxt[0].quo = item.a;
        st_nxt[0].dvs = item.b;
      end
      default: st_nxt[0].quo = '0;
    endcase
  end

  // Division steps, one quotient bit per stage. The first step also
  // adds the cross products of the multiply into its upper half.
  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    always_comb begin
      logic [64:0] t;
      logic [64:0] diff;
      logic        ge;
      t         = {st_r[k-1].rem, st_r[k-1].quo[63]};
      diff      = t - {1'b0, st_r[k-1].dvs};
      ge        = (t >= {1'b0, st_r[k-1].dvs});
      st_nxt[k] = st_r[k-1];
      if ((st_r[k-1].op == OP_DIV || st_r[k-1].op == OP_MOD) && !st_r[k-1].dz) begin
        st_nxt[k].rem = ge ? diff[63:0] : t[63:0];
        st_nxt[k].quo = {st_r[k-1].quo[62:0], ge};
      end
      if (k == 1 && st_r[k-1].op == OP_MUL) begin
        st_nxt[k].quo = st_r[k-1].quo +
                        {st_r[k-1].rem[63:32] + st_r[k-1].rem[31:0], 32'd0};
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTEP-1:0], !q_empty};
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= NSTEP; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  // Apply result signs, then wrap and extend to the operand width; a zero divisor gives a zero value with status set.
  always_comb begin
    mwa_stage_t  s;
    logic [63:0] r;
    s = st_r[NSTEP];
    case (s.op)
      OP_DIV:  r = s.neg_q ? (64'd0 - s.quo) : s.quo;
      OP_MOD:  r = s.neg_r ? (64'd0 - s.rem) : s.rem;
      default: r = s.quo;
    endcase
    fin.valid  = !s.dz;
    fin.status = s.dz;
    if (s.dz) begin
      fin.value = '0;
    end else if (s.ext_sign) begin
      fin.value = mwa_sext(r, s.width_sel);
    end else begin
      fin.value = r & mwa_mask(s.width_sel);
    end
  end

  // Two-entry output buffer.
  assign ofull     = (ocnt_r == 2'd2);
  assign out_empty = (ocnt_r == 2'd0);
  assign owr       = adv && vld_r[NSTEP];
  assign ord       = out_pop && !out_empty;

  assign out_result_value = ofifo_r[orp_r].value;
  assign out_result_valid = ofifo_r[orp_r].valid;
  assign out_status       = ofifo_r[orp_r].status;

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (owr && !ord) begin
      ocnt_nxt = ocnt_r + 2'd1;
    end else if (ord && !owr) begin
      ocnt_nxt = ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (owr) begin
        owp_r <= !owp_r;
      end
      if (ord) begin
        orp_r <= !orp_r;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (owr) begin
      ofifo_r[owp_r] <= fin;
    end
  end

  // A finished item is written into the output buffer only when it has room.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    owr |-> !ofull)
    else $error("output buffer written while full");

  // A stalled pipeline keeps its items in place.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during a stall");

  // A finished item blocked by a full buffer is not lost.
  a_last_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTEP] && ofull) |=> vld_r[NSTEP])
    else $error("blocked item dropped");

  // The buffer fill count never exceeds its two entries.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r != 2'd3)
    else $error("output buffer count out of range");

endmodule
